FILE: src/dq_pkg.sv
// Package for the double-ended queue: operation and status codes, default
// sizes and the command and status bundles between controller and datapath.
// Used by dq_ctrl, dq_datapath and double_ended_queue.
`timescale 1ns / 1ps

package dq_pkg;

  // Width of one element and default number of entries in the store.
  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // Operation codes carried by the op field; codes five to seven are ignored.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  // Status codes reported with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DUMP = 2'd1,
    S_WAIT = 2'd2
  } dq_state_t;

  // Commands from the controller to the datapath, at most one set per cycle.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic dump_start;
    logic dump_read;
    logic err_over;
    logic err_under;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } dq_stat_t;

endpackage

FILE: src/dq_ctrl.sv
// Controller of the double-ended queue: decodes each accepted item and
// sequences pops and dumps. Depends on dq_pkg; drives dq_datapath.
`timescale 1ns / 1ps

module dq_ctrl
  import dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] op,
  input  dq_stat_t   stat,
  output dq_cmd_t    cmd,
  output logic       busy
);

  dq_state_t state;
  dq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: pops wait in S_WAIT for the store read, dumps stream reads.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((op == OP_POP_FRONT || op == OP_POP_BACK) && !stat.empty) begin
            state_next = S_WAIT;
          end else if (op == OP_DUMP && !stat.empty) begin
            state_next = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (stat.dump_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Command decode.
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_PUSH_FRONT: begin
              cmd.err_over   = stat.full;
              cmd.push_front = !stat.full;
            end
            OP_PUSH_BACK: begin
              cmd.err_over  = stat.full;
              cmd.push_back = !stat.full;
            end
            OP_POP_FRONT: begin
              cmd.err_under = stat.empty;
              cmd.pop_front = !stat.empty;
            end
            OP_POP_BACK: begin
              cmd.err_under = stat.empty;
              cmd.pop_back  = !stat.empty;
            end
            OP_DUMP: begin
              cmd.err_under  = stat.empty;
              cmd.dump_start = !stat.empty;
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        cmd.dump_read = 1'b1;
      end
      S_WAIT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/dq_datapath.sv
// Datapath of the double-ended queue: circular element store, indices,
// occupancy, dump walker and result registers. Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dq_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0] value,
  output dq_stat_t                 stat,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] item,
  output logic [1:0]               status,
  output logic                     last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;

  logic [AW-1:0] front;
  logic [AW-1:0] back;
  logic [CW-1:0] count;
  logic [AW-1:0] dptr;
  logic [CW-1:0] dcnt;
  logic          rd_pend;
  logic          rd_last;

  logic [AW-1:0] front_inc;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] back_inc;
  logic [AW-1:0] back_dec;
  logic [AW-1:0] dptr_inc;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          we;
  logic          re;

  // Index arithmetic wrapping at the store depth.
  assign front_inc = (front == LAST_IDX) ? '0 : front + AW'(1);
  assign front_dec = (front == '0) ? LAST_IDX : front - AW'(1);
  assign back_inc  = (back == LAST_IDX) ? '0 : back + AW'(1);
  assign back_dec  = (back == '0) ? LAST_IDX : back - AW'(1);
  assign dptr_inc  = (dptr == LAST_IDX) ? '0 : dptr + AW'(1);

  // Status back to the controller.
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == FULL_CNT);
  assign stat.dump_last = (dcnt == CW'(1));

  // Store addresses. An empty queue takes its first item at the front index.
  always_comb begin
    we    = cmd.push_front | cmd.push_back;
    re    = cmd.pop_front | cmd.pop_back | cmd.dump_read;
    waddr = front;
    if (count != '0) begin
      waddr = cmd.push_front ? front_dec : back_inc;
    end
    raddr = dptr;
    if (cmd.pop_front) begin
      raddr = front;
    end else if (cmd.pop_back) begin
      raddr = back;
    end
  end

  // Element store with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Indices, occupancy and the dump walker.
  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      back    <= '0;
      count   <= '0;
      dcnt    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= re;
      if (cmd.push_front) begin
        if (count == '0) begin
          back <= front;
        end else begin
          front <= front_dec;
        end
        count <= count + CW'(1);
      end
      if (cmd.push_back) begin
        if (count == '0) begin
          back <= front;
        end else begin
          back <= back_inc;
        end
        count <= count + CW'(1);
      end
      if (cmd.pop_front) begin
        if (count > CW'(1)) begin
          front <= front_inc;
        end
        count <= count - CW'(1);
      end
      if (cmd.pop_back) begin
        if (count > CW'(1)) begin
          back <= back_dec;
        end
        count <= count - CW'(1);
      end
      if (cmd.dump_start) begin
        dcnt <= count;
      end
      if (cmd.dump_read) begin
        dcnt <= dcnt - CW'(1);
      end
    end
  end

  // Payload side of the walker and the pending read's last flag.
  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      dptr <= front;
    end else if (cmd.dump_read) begin
      dptr <= dptr_inc;
    end
    if (cmd.pop_front || cmd.pop_back) begin
      rd_last <= 1'b1;
    end else if (cmd.dump_read) begin
      rd_last <= (dcnt == CW'(1));
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= rd_pend | cmd.push_front | cmd.push_back | cmd.err_over | cmd.err_under;
    end
  end

  // Result payload: read data when a read is pending, else an acknowledgement.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      item   <= rdata;
      status <= ST_OK;
      last   <= rd_last;
    end else begin
      item <= '0;
      last <= 1'b1;
      if (cmd.err_over) begin
        status <= ST_OVER;
      end else if (cmd.err_under) begin
        status <= ST_UNDER;
      end else begin
        status <= ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  // Occupancy never goes beyond the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("occupancy exceeds depth");

  // With a single element both indices point at it.
  a_single_same: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(1)) |-> (front == back))
    else $error("indices differ with one element");

  // Every pending store read turns into a result in the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> strobe)
    else $error("pending read gave no result");

  // A pop changes occupancy by exactly one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back) |=> (count == $past(count) - CW'(1)))
    else $error("pop did not decrement occupancy");
`endif

endmodule

FILE: src/double_ended_queue.sv
// Push, overflow and underflow results appear in the cycle after the item is
// accepted, with busy staying low: one item per cycle. A pop result goes
// through the store read register, then the result registers; busy is high
// one cycle. A dump of N elements gives results one per cycle from the single
// store read port, busy high in S_DUMP and S_WAIT. Results cannot stall.
// Synchronous reset empties the queue; store contents are left as they are.
`timescale 1ns / 1ps

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               op,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] item,
  output logic [1:0]               status,
  output logic                     last
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // Controller: decodes items and sequences reads.
  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: store, indices and result registers.
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (value),
    .stat   (stat),
    .strobe (strobe),
    .item   (item),
    .status (status),
    .last   (last)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for double_ended_queue: directed and random deque
// operations, with a scoreboard class that mirrors the queue contents.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int N_RANDOM    = 170;
  localparam int SETTLE_WAIT = QDEPTH + 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  // One requested operation, and one result as seen on the output ports.
  typedef struct {
    logic [2:0]        op;
    logic [DATA_W-1:0] value;
  } deque_req_t;

  typedef struct {
    logic [DATA_W-1:0] item;
    logic [1:0]        status;
    logic              last;
  } deque_res_t;

  // Biases for the random operation mix.
  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} gen_mode_t;

  // Scoreboard: keeps its own copy of the deque and the results still owed.
  class deque_tracker;
    logic [DATA_W-1:0] contents [QDEPTH];
    int unsigned front_pos = 0;
    int unsigned back_pos  = 0;
    int unsigned fill      = 0;
    deque_res_t  due_results [$];
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned n_push = 0, n_pop = 0, n_dump = 0;
    int unsigned n_over = 0, n_under = 0, peak_fill = 0;

    function void owe(logic [DATA_W-1:0] it, logic [1:0] st, logic l);
      deque_res_t r;
      r.item   = it;
      r.status = st;
      r.last   = l;
      due_results.push_back(r);
    endfunction

    // Apply one accepted item to the mirror and queue up what it should give.
    function void accept_op(logic [2:0] o, logic [DATA_W-1:0] v);
      int unsigned p;
      case (o)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          n_push++;
          if (fill >= QDEPTH) begin
            n_over++;
            owe('0, ST_OVER, 1'b1);
          end else begin
            // An empty queue takes the value at the front position.
            if (fill == 0) begin
              back_pos = front_pos;
            end else if (o == OP_PUSH_FRONT) begin
              front_pos = (front_pos + QDEPTH - 1) % QDEPTH;
            end else begin
              back_pos = (back_pos + 1) % QDEPTH;
            end
            contents[(o == OP_PUSH_FRONT) ? front_pos : back_pos] = v;
            fill++;
            if (fill > peak_fill) peak_fill = fill;
            owe('0, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          n_pop++;
          if (fill == 0) begin
            n_under++;
            owe('0, ST_UNDER, 1'b1);
          end else if (o == OP_POP_FRONT) begin
            owe(contents[front_pos], ST_OK, 1'b1);
            if (fill > 1) front_pos = (front_pos + 1) % QDEPTH;
            fill--;
          end else begin
            owe(contents[back_pos], ST_OK, 1'b1);
            if (fill > 1) back_pos = (back_pos + QDEPTH - 1) % QDEPTH;
            fill--;
          end
        end
        OP_DUMP: begin
          n_dump++;
          if (fill == 0) begin
            n_under++;
            owe('0, ST_UNDER, 1'b1);
          end else begin
            // Every element from front to back, the final one flagged.
            p = front_pos;
            for (int i = 0; i < fill; i++) begin
              owe(contents[p], ST_OK, (i == fill - 1));
              p = (p + 1) % QDEPTH;
            end
          end
        end
        default: ; // unused codes leave the queue alone and give nothing
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    // Compare one strobed result with the oldest one owed.
    function void check_result(logic [DATA_W-1:0] it, logic [1:0] st, logic l);
      deque_res_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result item=%h status=%0d last=%0b", it, st, l));
        return;
      end
      want = due_results.pop_front();
      if (it !== want.item || st !== want.status || l !== want.last) begin
        report($sformatf({"result %0d: expected item=%h status=%0d last=%0b,",
                          " got item=%h status=%0d last=%0b"},
                         results_seen, want.item, want.status, want.last, it, st, l));
      end
    endfunction
  endclass

  logic                     clk   = 1'b0;
  logic                     rst   = 1'b1;
  logic                     start = 1'b0;
  logic [2:0]               op    = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     strobe;
  logic signed [DATA_W-1:0] item;
  logic [1:0]               status;
  logic                     last;

  deque_tracker tracker = new;
  deque_req_t   plan [$];
  int unsigned  random_count = 0;
  int unsigned  cycle_count  = 0;

  double_ended_queue #(.DEPTH(QDEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .value  (value),
    .strobe (strobe),
    .item   (item),
    .status (status),
    .last   (last)
  );

  always #5 clk = ~clk;

  // Cycle counter for the watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Results cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    if (!rst && strobe) tracker.check_result(item, status, last);
  end

  function automatic void add_req(logic [2:0] o, logic [DATA_W-1:0] v);
    deque_req_t r;
    r.op    = o;
    r.value = v;
    plan.push_back(r);
  endfunction

  // Mostly full-range values, with the extremes now and then.
  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // One random item, biased towards pushes or pops by the mode.
  function automatic void add_random_req(gen_mode_t mode);
    int unsigned r;
    int unsigned push_pct;
    r = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 92 : (mode == MODE_DRAIN) ? 10 : 48;
    if (r < 3) begin
      add_req(3'($urandom_range(5, 7)), $urandom);
    end else begin
      random_count++;
      if (r < 8) begin
        add_req(OP_DUMP, $urandom);
      end else if ($urandom_range(0, 99) < push_pct) begin
        add_req(($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value());
      end else begin
        add_req(($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
      end
    end
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_req(deque_req_t req);
    start <= 1'b1;
    op    <= req.op;
    value <= req.value;
    do @(posedge clk); while (busy);
    tracker.accept_op(req.op, req.value);
  endtask

  // Sender gap; the data ports carry junk meanwhile.
  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    op    <= 3'($urandom);
    value <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, tracker.due_results.size());
    $display("[double_ended_queue] ERROR");
    $finish;
  end

  initial begin
    int unsigned pos;
    int unsigned burst;
    int unsigned len;
    gen_mode_t   mode;

    // Directed part: empty-queue underflows, ignored codes, extreme values,
    // front wrap below position zero and removal of the sole element.
    add_req(OP_POP_FRONT,  32'h1234_5678);
    add_req(OP_POP_BACK,   32'hFFFF_FFFF);
    add_req(OP_DUMP,       32'h0000_0000);
    add_req(3'd5,          32'hDEAD_BEEF);
    add_req(3'd6,          32'h0000_0001);
    add_req(3'd7,          32'hFFFF_FFFF);
    add_req(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    add_req(OP_PUSH_FRONT, 32'h8000_0000);
    add_req(OP_PUSH_BACK,  32'h0000_0000);
    add_req(OP_PUSH_BACK,  32'hFFFF_FFFF);
    add_req(OP_DUMP,       32'h5555_5555);
    add_req(OP_POP_FRONT,  32'h0);
    add_req(OP_POP_BACK,   32'h0);
    add_req(OP_POP_BACK,   32'h0);
    add_req(OP_POP_FRONT,  32'h0);
    add_req(OP_POP_FRONT,  32'h0);
    add_req(OP_PUSH_BACK,  32'h5555_5555);
    add_req(OP_DUMP,       32'h0);
    add_req(OP_POP_BACK,   32'h0);
    add_req(OP_PUSH_BACK,  32'hAAAA_AAAA);
    add_req(OP_POP_FRONT,  32'h0);
    add_req(OP_PUSH_FRONT, $urandom);
    add_req(OP_DUMP,       32'h0);
    add_req(OP_POP_BACK,   32'h0);

    // Random part: a long filling run first so that the queue overflows,
    // then runs of random length and bias.
    for (int i = 0; i < 100; i++) add_random_req(MODE_FILL);
    while (random_count < N_RANDOM) begin
      mode = gen_mode_t'($urandom_range(0, 2));
      len  = $urandom_range(15, 60);
      for (int i = 0; i < len && random_count < N_RANDOM; i++) add_random_req(mode);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Bursts of random length, now and then long ones, with gaps between.
    pos = 0;
    while (pos < plan.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < burst && pos < plan.size(); k++) begin
        send_req(plan[pos]);
        pos++;
      end
      if (pos < plan.size() && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    start <= 1'b0;

    // Drain what is still owed, then allow for a trailing dump.
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Covered %0d pushes, %0d pops and %0d dumps; occupancy peaked at %0d of %0d.",
             tracker.n_push, tracker.n_pop, tracker.n_dump, tracker.peak_fill, QDEPTH);
    $display("Checked %0d results, %0d overflows and %0d underflows among them;",
             tracker.results_seen, tracker.n_over, tracker.n_under);
    $display("%0d mismatches.", tracker.errors);
    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue.sv
tb/sv/tb_top.sv
